// ===== hdl/tod_pkg.sv =====
// Shared constants, register indexes and types of the transient onset detector.
`default_nettype none

package tod_pkg;

  // Sample and datapath widths.
  localparam int SAMPLE_BITS = 24;
  localparam int AMP_W       = 32;
  localparam int COEF_W      = 16;
  localparam int PROD_W      = AMP_W + COEF_W;
  localparam int THR_W       = PROD_W - 8;
  localparam int CNT_W       = 48;
  localparam int REFR_W      = 20;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_RELEASE_COEF  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FLOOR_COEF    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_TRIGGER_RATIO = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_ABS_FLOOR     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_REFRACTORY    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_ECHO_START    = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_ECHO_DECAY    = 3'd6;

  // Register reset values.
  localparam logic [COEF_W-1:0] RELEASE_COEF_RST  = 16'd91;
  localparam logic [COEF_W-1:0] FLOOR_COEF_RST    = 16'd3;
  localparam logic [COEF_W-1:0] TRIGGER_RATIO_RST = 16'd2560;
  localparam logic [AMP_W-1:0]  ABS_FLOOR_RST     = 32'd0;
  localparam logic [REFR_W-1:0] REFRACTORY_RST    = 20'd4800;
  localparam logic [COEF_W-1:0] ECHO_START_RST    = 16'd16384;
  localparam logic [COEF_W-1:0] ECHO_DECAY_RST    = 16'd65400;

  // Noise floor after reset: full scale over one thousand, Q24.8.
  localparam logic [AMP_W-1:0] FLOOR_RST = 32'd2147484;

  // Operands handed to the shared multiplier.
  typedef struct packed {
    logic [AMP_W-1:0]  a;
    logic [COEF_W-1:0] b;
  } mul_req_t;

endpackage

`default_nettype wire

// ===== hdl/tod_mul.sv =====
// Shared 32x16 unsigned multiplier with a registered product.
`default_nettype none

module tod_mul (
  input  wire logic                        clk,
  input  wire tod_pkg::mul_req_t           req,
  output logic [tod_pkg::PROD_W-1:0]       prod_r
);

  logic [tod_pkg::PROD_W-1:0] prod_nxt;

  // One product per cycle; the sequencer picks it up in the next step.
  always_comb begin
    prod_nxt = tod_pkg::PROD_W'(req.a) * tod_pkg::PROD_W'(req.b);
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/transient_onset_detector_unit.sv =====
// Top level of the transient onset detector: sequencer, state and output register.
//
// Use: one signed microphone sample enters per item on the in_ channel
// (in_valid/in_ready). Each item gives exactly one result on the out_ channel
// (out_valid/out_ready): onset and echo flags, the sample index since reset,
// and the envelope and noise floor after the sample.
// After an item is accepted, the release, echo, threshold and compare steps run
// in turn and the update step loads the output register. One item is handled at
// a time, paced by the single 32x16 multiplier that the sequencer uses in four
// successive steps (release, echo decay, threshold, echo load or floor tracking).
// in_ready is high only while the sequencer is idle. A finished result waits
// in the output register while the next item is taken in; if the receiver
// still stalls when the next result is ready, the sequencer holds in its last
// step until the output register frees.
// Reset (rst_n low, synchronous) restores the configuration registers to their
// defaults, clears the envelope, echo guard, counter and refractory window, and
// sets the noise floor to full scale over one thousand. Configuration is written
// through cfg_we/cfg_addr/cfg_wdata at any edge; unknown indexes are ignored.
`default_nettype none

module transient_onset_detector_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // Input channel
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [tod_pkg::SAMPLE_BITS-1:0] in_sample_a,
  // Result channel
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic                                      out_onset,
  output logic                                      out_echo_reject,
  output logic [tod_pkg::CNT_W-1:0]                 out_sample_number,
  output logic [tod_pkg::AMP_W-1:0]                 out_envelope_level,
  output logic [tod_pkg::AMP_W-1:0]                 out_floor_level,
  // Configuration port
  input  wire logic                                 cfg_we,
  input  wire logic [tod_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  wire logic [tod_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_REL  = 3'd1;
  localparam logic [2:0] ST_ECHO = 3'd2;
  localparam logic [2:0] ST_THR  = 3'd3;
  localparam logic [2:0] ST_CMP  = 3'd4;
  localparam logic [2:0] ST_UPD  = 3'd5;

  localparam int AW = tod_pkg::AMP_W;
  localparam int CW = tod_pkg::COEF_W;
  localparam int MAG_EXT_W = 40;

  // Configuration registers.
  logic [CW-1:0]              release_coef_r;
  logic [CW-1:0]              floor_coef_r;
  logic [CW-1:0]              trigger_ratio_r;
  logic [AW-1:0]              abs_floor_r;
  logic [tod_pkg::REFR_W-1:0] refractory_r;
  logic [CW-1:0]              echo_start_r;
  logic [CW-1:0]              echo_decay_r;

  // Detector state.
  logic [2:0]                 state_r, state_nxt;
  logic [AW-1:0]              env_r;
  logic [AW-1:0]              nf_r;
  logic [AW-1:0]              eg_r;
  logic [tod_pkg::CNT_W-1:0]  cnt_r;
  logic [tod_pkg::REFR_W-1:0] refr_r;

  // Per-item working registers.
  logic [AW-1:0]              amp_r;
  logic [tod_pkg::CNT_W-1:0]  idx_r;
  logic                       blocked_r;
  logic                       attack_r;
  logic                       trig_r;
  logic                       floor_up_r;

  // Output register.
  logic                       out_valid_r;
  logic                       out_onset_r;
  logic                       out_echo_r;
  logic [tod_pkg::CNT_W-1:0]  out_idx_r;
  logic [AW-1:0]              out_env_r;
  logic [AW-1:0]              out_nf_r;

  logic                       in_fire;
  logic                       upd_go;
  logic [tod_pkg::SAMPLE_BITS-1:0] mag;
  logic [MAG_EXT_W-1:0]       mag_q8;
  logic [AW-1:0]              amp_c;
  logic [tod_pkg::REFR_W-1:0] refr_dec;
  logic [tod_pkg::THR_W-1:0]  thr_c;
  logic                       trig_c;
  logic                       floor_up_c;
  logic [AW-1:0]              load_c;
  logic                       echo_c;
  tod_pkg::mul_req_t          mul_req;
  logic [tod_pkg::PROD_W-1:0] prod_r;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign upd_go   = (state_r == ST_UPD) && (!out_valid_r || out_ready);

  // Magnitude of the sample in Q.8, saturated to 32 bits.
  always_comb begin
    mag    = in_sample_a[tod_pkg::SAMPLE_BITS-1] ? (~in_sample_a + 1'b1) : in_sample_a;
    mag_q8 = MAG_EXT_W'(mag) << 8;
    amp_c  = (|mag_q8[MAG_EXT_W-1:AW]) ? '1 : mag_q8[AW-1:0];
  end

  // Refractory countdown applied as the item enters.
  assign refr_dec = (refr_r != '0) ? refr_r - 1'b1 : refr_r;

  // Threshold test on the registered threshold product.
  always_comb begin
    thr_c = prod_r[tod_pkg::PROD_W-1:8];
    if (tod_pkg::THR_W'(abs_floor_r) > thr_c) begin
      thr_c = tod_pkg::THR_W'(abs_floor_r);
    end
    trig_c     = !blocked_r && (tod_pkg::THR_W'(env_r) > thr_c);
    floor_up_c = env_r >= nf_r;
  end

  // Echo load and echo judgment for the update step.
  assign load_c = prod_r[tod_pkg::PROD_W-1:CW];
  assign echo_c = env_r <= eg_r;

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_req = '0;
    unique case (state_r)
      ST_REL: begin
        mul_req.a = env_r - amp_r;
        mul_req.b = release_coef_r;
      end
      ST_ECHO: begin
        mul_req.a = eg_r;
        mul_req.b = echo_decay_r;
      end
      ST_THR: begin
        mul_req.a = nf_r;
        mul_req.b = trigger_ratio_r;
      end
      ST_CMP: begin
        if (trig_c) begin
          mul_req.a = env_r;
          mul_req.b = echo_start_r;
        end else begin
          mul_req.a = floor_up_c ? (env_r - nf_r) : (nf_r - env_r);
          mul_req.b = floor_coef_r;
        end
      end
      ST_UPD: begin
        // The same product is formed again while the result waits for the receiver.
        if (trig_r) begin
          mul_req.a = env_r;
          mul_req.b = echo_start_r;
        end else begin
          mul_req.a = floor_up_r ? (env_r - nf_r) : (nf_r - env_r);
          mul_req.b = floor_coef_r;
        end
      end
      default: begin
        mul_req = '0;
      end
    endcase
  end

  tod_mul u_mul (
    .clk    (clk),
    .req    (mul_req),
    .prod_r (prod_r)
  );

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_REL;
      ST_REL:  state_nxt = ST_ECHO;
      ST_ECHO: state_nxt = ST_THR;
      ST_THR:  state_nxt = ST_CMP;
      ST_CMP:  state_nxt = ST_UPD;
      ST_UPD:  if (upd_go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      release_coef_r  <= tod_pkg::RELEASE_COEF_RST;
      floor_coef_r    <= tod_pkg::FLOOR_COEF_RST;
      trigger_ratio_r <= tod_pkg::TRIGGER_RATIO_RST;
      abs_floor_r     <= tod_pkg::ABS_FLOOR_RST;
      refractory_r    <= tod_pkg::REFRACTORY_RST;
      echo_start_r    <= tod_pkg::ECHO_START_RST;
      echo_decay_r    <= tod_pkg::ECHO_DECAY_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        tod_pkg::REG_RELEASE_COEF:  release_coef_r  <= cfg_wdata[CW-1:0];
        tod_pkg::REG_FLOOR_COEF:    floor_coef_r    <= cfg_wdata[CW-1:0];
        tod_pkg::REG_TRIGGER_RATIO: trigger_ratio_r <= cfg_wdata[CW-1:0];
        tod_pkg::REG_ABS_FLOOR:     abs_floor_r     <= cfg_wdata[AW-1:0];
        tod_pkg::REG_REFRACTORY:    refractory_r    <= cfg_wdata[tod_pkg::REFR_W-1:0];
        tod_pkg::REG_ECHO_START:    echo_start_r    <= cfg_wdata[CW-1:0];
        tod_pkg::REG_ECHO_DECAY:    echo_decay_r    <= cfg_wdata[CW-1:0];
        default: ;
      endcase
    end
  end

  // Detector state and sequencer steps.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      env_r      <= '0;
      nf_r       <= tod_pkg::FLOOR_RST;
      eg_r       <= '0;
      cnt_r      <= '0;
      refr_r     <= '0;
      blocked_r  <= 1'b0;
      attack_r   <= 1'b0;
      trig_r     <= 1'b0;
      floor_up_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            amp_r     <= amp_c;
            idx_r     <= cnt_r;
            cnt_r     <= cnt_r + 1'b1;
            refr_r    <= refr_dec;
            blocked_r <= refr_dec != '0;
          end
        end
        ST_REL: begin
          // Instant attack; release product is formed meanwhile.
          attack_r <= amp_r > env_r;
          if (amp_r > env_r) begin
            env_r <= amp_r;
          end
        end
        ST_ECHO: begin
          if (!attack_r) begin
            env_r <= env_r - prod_r[tod_pkg::PROD_W-1:CW];
          end
        end
        ST_THR: begin
          eg_r <= prod_r[tod_pkg::PROD_W-1:CW];
        end
        ST_CMP: begin
          trig_r     <= trig_c;
          floor_up_r <= floor_up_c;
        end
        ST_UPD: begin
          if (upd_go && !blocked_r) begin
            if (trig_r) begin
              refr_r <= refractory_r;
              if (load_c > eg_r) begin
                eg_r <= load_c;
              end
            end else if (floor_up_r) begin
              nf_r <= nf_r + prod_r[tod_pkg::PROD_W-1:CW];
            end else begin
              nf_r <= nf_r - prod_r[tod_pkg::PROD_W-1:CW];
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Output register: loaded in the update step, freed when taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (upd_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go) begin
      out_onset_r <= !blocked_r && trig_r && !echo_c;
      out_echo_r  <= !blocked_r && trig_r && echo_c;
      out_idx_r   <= idx_r;
      out_env_r   <= env_r;
      if (!blocked_r && !trig_r) begin
        out_nf_r <= floor_up_r ? nf_r + prod_r[tod_pkg::PROD_W-1:CW]
                               : nf_r - prod_r[tod_pkg::PROD_W-1:CW];
      end else begin
        out_nf_r <= nf_r;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_onset          = out_onset_r;
  assign out_echo_reject    = out_echo_r;
  assign out_sample_number  = out_idx_r;
  assign out_envelope_level = out_env_r;
  assign out_floor_level    = out_nf_r;

  // An accepted item always starts the release step.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == ST_REL)
    else $error("accepted item did not start the sequencer");

  // A result never carries both flags.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_onset_r && out_echo_r))
    else $error("onset and echo reject both set");

  // A trigger reloads the refractory window.
  a_trigger_loads_refr: assert property (@(posedge clk) disable iff (!rst_n)
    (upd_go && trig_r && !blocked_r) |=> refr_r == $past(refractory_r))
    else $error("trigger did not load the refractory window");

  // A new result only appears out of the update step.
  a_result_from_update: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_UPD)
    else $error("result appeared outside the update step");

  // No new item is taken while the sequencer is busy.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready)
    else $error("item accepted while busy");

endmodule

`default_nettype wire
